/* hdl/rtfe_pkg.sv */
// Shared types, microcode table and decode helpers for the RTF text escaper.
// Standalone package; used by rtf_text_escaper.

package rtfe_pkg;

    localparam int unsigned PC_W = 7;

    typedef logic [PC_W-1:0] pc_t;

    // Micro-operations of the sequencer
    typedef enum logic [2:0] {
        OP_CHAR,       // emit the word's literal byte
        OP_CHAR_DISP,  // emit literal byte, then jump to the tail chosen at decode
        OP_CODE,       // emit low byte of the code unit
        OP_SIGN,       // emit '-' for a negative code, else no transfer
        OP_DIGIT       // emit one decimal digit, leading zeros suppressed
    } uop_t;

    typedef struct packed {
        uop_t       op;
        logic [7:0] ch;
        logic [2:0] pow;   // decimal place for OP_DIGIT
        logic       last;  // final step of the run
    } ucode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // Control store layout
    localparam pc_t A_ESC     = 7'd0;
    localparam pc_t A_BSLASH  = 7'd1;
    localparam pc_t A_LBRACE  = 7'd2;
    localparam pc_t A_RBRACE  = 7'd3;
    localparam pc_t A_TAB     = 7'd4;
    localparam pc_t A_TAB_E   = 7'd7;
    localparam pc_t A_NBSP    = 7'd8;
    localparam pc_t A_SHY     = 7'd9;
    localparam pc_t A_EMD     = 7'd10;
    localparam pc_t A_EMD_E   = 7'd16;
    localparam pc_t A_END     = 7'd17;
    localparam pc_t A_END_E   = 7'd23;
    localparam pc_t A_LQ      = 7'd24;
    localparam pc_t A_LQ_E    = 7'd30;
    localparam pc_t A_RQ      = 7'd31;
    localparam pc_t A_RQ_E    = 7'd37;
    localparam pc_t A_LDQ     = 7'd38;
    localparam pc_t A_LDQ_E   = 7'd47;
    localparam pc_t A_RDQ     = 7'd48;
    localparam pc_t A_RDQ_E   = 7'd57;
    localparam pc_t A_UNI     = 7'd58;
    localparam pc_t A_SIGN    = 7'd59;
    localparam pc_t A_DIG4    = 7'd60;
    localparam pc_t A_DIG0    = 7'd64;
    localparam pc_t A_QMARK   = 7'd65;
    localparam pc_t A_PASS    = 7'd66;

    localparam logic [87:0] S_TAB = 88'("tab ");
    localparam logic [87:0] S_EMD = 88'("emdash ");
    localparam logic [87:0] S_END = 88'("endash ");
    localparam logic [87:0] S_LQ  = 88'("lquote ");
    localparam logic [87:0] S_RQ  = 88'("rquote ");
    localparam logic [87:0] S_LDQ = 88'("ldblquote ");
    localparam logic [87:0] S_RDQ = 88'("rdblquote ");

    // Character counted from the end of a right-aligned string
    function automatic logic [7:0] char_at(input logic [87:0] s,
                                           input logic [3:0] from_end);
        return s[{from_end, 3'b000} +: 8];
    endfunction

    function automatic ucode_t str_word(input logic [87:0] s, input pc_t addr,
                                        input pc_t last_addr);
        ucode_t w;
        pc_t    off;
        off    = last_addr - addr;
        w.op   = OP_CHAR;
        w.ch   = char_at(s, off[3:0]);
        w.pow  = 3'd0;
        w.last = (addr == last_addr);
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input pc_t addr);
        ucode_t w;
        pc_t    dig;
        w   = '{op: OP_CHAR, ch: CH_BSLASH, pow: 3'd0, last: 1'b1};
        dig = A_DIG0 - addr;
        priority if (addr == A_ESC)
            w = '{op: OP_CHAR_DISP, ch: CH_BSLASH, pow: 3'd0, last: 1'b0};
        else if (addr == A_BSLASH)
            w.ch = CH_BSLASH;
        else if (addr == A_LBRACE)
            w.ch = 8'h7B;
        else if (addr == A_RBRACE)
            w.ch = 8'h7D;
        else if (addr <= A_TAB_E)
            w = str_word(S_TAB, addr, A_TAB_E);
        else if (addr == A_NBSP)
            w.ch = 8'h7E;
        else if (addr == A_SHY)
            w.ch = CH_MINUS;
        else if (addr <= A_EMD_E)
            w = str_word(S_EMD, addr, A_EMD_E);
        else if (addr <= A_END_E)
            w = str_word(S_END, addr, A_END_E);
        else if (addr <= A_LQ_E)
            w = str_word(S_LQ, addr, A_LQ_E);
        else if (addr <= A_RQ_E)
            w = str_word(S_RQ, addr, A_RQ_E);
        else if (addr <= A_LDQ_E)
            w = str_word(S_LDQ, addr, A_LDQ_E);
        else if (addr <= A_RDQ_E)
            w = str_word(S_RDQ, addr, A_RDQ_E);
        else if (addr == A_UNI)
            w = '{op: OP_CHAR, ch: 8'h75, pow: 3'd0, last: 1'b0};
        else if (addr == A_SIGN)
            w = '{op: OP_SIGN, ch: CH_MINUS, pow: 3'd0, last: 1'b0};
        else if (addr <= A_DIG0)
            w = '{op: OP_DIGIT, ch: CH_ZERO, pow: dig[2:0], last: 1'b0};
        else if (addr == A_QMARK)
            w.ch = CH_QMARK;
        else
            // A_PASS; addresses above it are never reached
            w = '{op: OP_CODE, ch: 8'h00, pow: 3'd0, last: 1'b1};
        return w;
    endfunction

    // Tail entry chosen at decode; A_PASS marks a plain single byte
    function automatic pc_t tail_entry(input logic [15:0] code);
        pc_t a;
        unique case (code)
            16'h005C: a = A_BSLASH;
            16'h007B: a = A_LBRACE;
            16'h007D: a = A_RBRACE;
            16'h0009: a = A_TAB;
            16'h00A0: a = A_NBSP;
            16'h00AD: a = A_SHY;
            16'h2014: a = A_EMD;
            16'h2013: a = A_END;
            16'h2018: a = A_LQ;
            16'h2019: a = A_RQ;
            16'h201C: a = A_LDQ;
            16'h201D: a = A_RDQ;
            default:  a = (code > 16'd127) ? A_UNI : A_PASS;
        endcase
        return a;
    endfunction

    // j times the power of ten for decimal place k
    function automatic logic [16:0] digit_thr(input logic [2:0] k, input int unsigned j);
        logic [16:0] t;
        unique case (k)
            3'd1:    t = 17'(j * 10);
            3'd2:    t = 17'(j * 100);
            3'd3:    t = 17'(j * 1000);
            3'd4:    t = 17'(j * 10000);
            default: t = 17'(j);
        endcase
        return t;
    endfunction

endpackage

/* hdl/rtf_text_escaper.sv */
// An input transfer loads the sequencer; its first output byte is then registered in the output stage.
// The sequencer runs one step per cycle from a microcode table unless an emitting step waits;
// plain codes are a single step, other escapes a backslash step followed by their tail steps.
// A step that emits waits while the output byte is held; steps with no transfer run on.
// Reset (rst_n low, asynchronous) idles the sequencer and empties the output.
// Depends on rtfe_pkg.

module rtf_text_escaper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // run_last
);

    logic              busy_reg, busy_next;
    rtfe_pkg::pc_t     pc_reg, pc_next;
    rtfe_pkg::pc_t     tail_reg, tail_next;
    logic [15:0]       code_reg, code_next;
    logic [15:0]       mag_reg, mag_next;
    logic              started_reg, started_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    rtfe_pkg::ucode_t  word;
    rtfe_pkg::pc_t     in_tail;
    logic              emit, fire, accept, out_free;
    logic [7:0]        emit_byte;
    logic [3:0]        digit;
    logic [16:0]       digit_sub;

    assign word    = rtfe_pkg::ucode_rom(pc_reg);
    assign in_tail = rtfe_pkg::tail_entry(s_axis_tdata);

    // Digit by parallel compare against the multiples of the current place
    always_comb
    begin
        digit     = 4'd0;
        digit_sub = 17'd0;
        for (int unsigned j = 1; j <= 9; j++)
        begin
            if ({1'b0, mag_reg} >= rtfe_pkg::digit_thr(word.pow, j))
            begin
                digit     = 4'(j);
                digit_sub = rtfe_pkg::digit_thr(word.pow, j);
            end
        end
    end

    always_comb
    begin
        unique case (word.op)
            rtfe_pkg::OP_CODE:
            begin
                emit      = 1'b1;
                emit_byte = code_reg[7:0];
            end
            rtfe_pkg::OP_SIGN:
            begin
                emit      = code_reg[15];
                emit_byte = word.ch;
            end
            rtfe_pkg::OP_DIGIT:
            begin
                // ones place always prints so zero shows as "0"
                emit      = (digit != 4'd0) || started_reg || (word.pow == 3'd0);
                emit_byte = word.ch + {4'd0, digit};
            end
            default:
            begin
                emit      = 1'b1;
                emit_byte = word.ch;
            end
        endcase
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = busy_reg && (!emit || out_free);
    assign s_axis_tready = !busy_reg || (fire && word.last);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        tail_next      = tail_reg;
        code_next      = code_reg;
        mag_next       = mag_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (fire)
        begin
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_data_next  = emit_byte;
                out_last_next  = word.last;
            end
            if (word.op == rtfe_pkg::OP_DIGIT)
            begin
                mag_next     = mag_reg - digit_sub[15:0];
                started_next = started_reg || (digit != 4'd0);
            end
            if (word.last)
                busy_next = 1'b0;
            else if (word.op == rtfe_pkg::OP_CHAR_DISP)
                pc_next = tail_reg;
            else
                pc_next = pc_reg + rtfe_pkg::pc_t'(1);
        end

        if (accept)
        begin
            busy_next    = 1'b1;
            tail_next    = in_tail;
            pc_next      = (in_tail == rtfe_pkg::A_PASS) ? rtfe_pkg::A_PASS : rtfe_pkg::A_ESC;
            code_next    = s_axis_tdata;
            mag_next     = s_axis_tdata[15] ? (16'd0 - s_axis_tdata) : s_axis_tdata;
            started_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= rtfe_pkg::A_PASS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg     <= tail_next;
        code_reg     <= code_next;
        mag_reg      <= mag_next;
        started_reg  <= started_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* tb/tb_rtf_text_escaper.sv */
// Self-checking testbench for rtf_text_escaper: drives UTF-16 code units, predicts each
// escaped byte run and checks every output byte and its last flag.
// Depends on the rtf_text_escaper RTL only.
`timescale 1ns / 100ps

module tb_rtf_text_escaper;

    localparam int unsigned CYCLE_LIMIT = 250000;
    localparam int unsigned SETTLE_CYCLES = 16;

    localparam logic [15:0] CP_TAB     = 16'h0009;
    localparam logic [15:0] CP_LF      = 16'h000A;
    localparam logic [15:0] CP_BSLASH  = 16'h005C;
    localparam logic [15:0] CP_LBRACE  = 16'h007B;
    localparam logic [15:0] CP_RBRACE  = 16'h007D;
    localparam logic [15:0] CP_DEL     = 16'h007F;
    localparam logic [15:0] CP_NBSP    = 16'h00A0;
    localparam logic [15:0] CP_SHY     = 16'h00AD;
    localparam logic [15:0] CP_ENDASH  = 16'h2013;
    localparam logic [15:0] CP_EMDASH  = 16'h2014;
    localparam logic [15:0] CP_LQUOTE  = 16'h2018;
    localparam logic [15:0] CP_RQUOTE  = 16'h2019;
    localparam logic [15:0] CP_LDQUOTE = 16'h201C;
    localparam logic [15:0] CP_RDQUOTE = 16'h201D;
    localparam logic [15:0] CP_MOST_NEG = 16'h8000;

    localparam logic [15:0] ESCAPED_CODES [12] = '{
        CP_TAB, CP_BSLASH, CP_LBRACE, CP_RBRACE, CP_NBSP, CP_SHY,
        CP_ENDASH, CP_EMDASH, CP_LQUOTE, CP_RQUOTE, CP_LDQUOTE, CP_RDQUOTE
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rtf_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] code_unit
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tlast;   // run_last

    logic [15:0] codes_to_send [$];
    rtf_byte_t   rtf_bytes_due [$];

    bit          throttle;
    int unsigned codes_queued;
    int unsigned codes_accepted;
    int unsigned bytes_checked;
    int unsigned escaped_runs;
    int unsigned errors;
    int unsigned cycles;

    rtf_text_escaper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Expected RTF bytes for one code unit, appended to the due queue
    task automatic rtf_escape(input logic [15:0] code);
        string      word;
        int         value;
        rtf_byte_t  b;
        word = "";
        case (code)
            CP_BSLASH:  word = "\\\\";
            CP_LBRACE:  word = "\\{";
            CP_RBRACE:  word = "\\}";
            CP_TAB:     word = "\\tab ";
            CP_NBSP:    word = "\\~";
            CP_SHY:     word = "\\-";
            CP_EMDASH:  word = "\\emdash ";
            CP_ENDASH:  word = "\\endash ";
            CP_LQUOTE:  word = "\\lquote ";
            CP_RQUOTE:  word = "\\rquote ";
            CP_LDQUOTE: word = "\\ldblquote ";
            CP_RDQUOTE: word = "\\rdblquote ";
            default:
            begin
                if (code > 16'd127)
                begin
                    value = code[15] ? int'(code) - 65536 : int'(code);
                    word = $sformatf("\\u%0d?", value);
                end
            end
        endcase
        if (word.len() == 0)
        begin
            // plain code, may be NUL, so not built as a string
            b.data = code[7:0];
            b.last = 1'b1;
            rtf_bytes_due.push_back(b);
        end
        else
        begin
            escaped_runs++;
            for (int i = 0; i < word.len(); i++)
            begin
                b.data = word[i];
                b.last = (i == word.len() - 1);
                rtf_bytes_due.push_back(b);
            end
        end
    endtask

    function automatic logic [15:0] pick_code();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return 16'($urandom_range(127));
        else if (sel < 58)
            return ESCAPED_CODES[$urandom_range(11)];
        else if (sel < 72)
            return 16'($urandom_range(16'h07FF, 16'h0080));
        else
            return 16'($urandom);
    endfunction

    task automatic queue_code(input logic [15:0] code);
        codes_to_send.push_back(code);
        codes_queued++;
    endtask

    task automatic wait_drained();
        while (codes_accepted != codes_queued || rtf_bytes_due.size() != 0)
            @(negedge clk);
    endtask

    // Source side, plus sink tready: tvalid stays up until the transfer happens
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (codes_to_send.size() != 0 && !(throttle && $urandom_range(99) < 28))
                begin
                    s_axis_tdata  <= codes_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= !(throttle && $urandom_range(99) < 28);
        end
    end

    // Prediction on each input transfer, check on each output transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                rtf_escape(s_axis_tdata);
                codes_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                bytes_checked++;
                if (rtf_bytes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected byte: expected none, actual data=%h last=%b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    if (rtf_bytes_due[0].data !== m_axis_tdata)
                    begin
                        errors++;
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, rtf_bytes_due[0].data, m_axis_tdata);
                    end
                    if (rtf_bytes_due[0].last !== m_axis_tlast)
                    begin
                        errors++;
                        $display("%0t: run_last mismatch: expected %b, actual %b",
                                 $time, rtf_bytes_due[0].last, m_axis_tlast);
                    end
                    void'(rtf_bytes_due.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d codes accepted, %0d bytes still due",
                     $time, codes_accepted, rtf_bytes_due.size());
            $display("tb_rtf_text_escaper: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        throttle       = 1'b1;
        codes_queued   = 0;
        codes_accepted = 0;
        bytes_checked  = 0;
        escaped_runs   = 0;
        errors         = 0;
        cycles         = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: control characters, ASCII boundary values, every escaped code, \u extremes
        queue_code(16'h0000);
        queue_code(CP_TAB);
        queue_code(CP_LF);
        queue_code(16'h0041);
        queue_code(CP_BSLASH);
        queue_code(CP_LBRACE);
        queue_code(CP_RBRACE);
        queue_code(CP_DEL);
        queue_code(16'h0080);
        queue_code(CP_NBSP);
        queue_code(CP_SHY);
        queue_code(16'h00FF);
        queue_code(CP_ENDASH);
        queue_code(CP_EMDASH);
        queue_code(CP_LQUOTE);
        queue_code(CP_RQUOTE);
        queue_code(CP_LDQUOTE);
        queue_code(CP_RDQUOTE);
        queue_code(16'h2710);
        queue_code(16'h7FFF);
        queue_code(CP_MOST_NEG);
        queue_code(16'hD83D);   // surrogate pair, each half escaped alone
        queue_code(16'hDE00);
        queue_code(16'hFFFF);
        queue_code(16'h5555);
        queue_code(16'hAAAA);

        // Hold the source until every due byte is out
        wait_drained();

        for (int i = 0; i < 150; i++)
            queue_code(pick_code());
        wait_drained();

        throttle = 1'b0;
        for (int i = 0; i < 100; i++)
            queue_code(pick_code());
        wait_drained();

        throttle = 1'b1;
        for (int i = 0; i < 150; i++)
            queue_code(pick_code());
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d code units sent (%0d escaped), %0d RTF bytes checked", codes_accepted,
                 escaped_runs, bytes_checked);
        $display("covered all escape words, ASCII passthrough and signed \\u forms");
        if (errors == 0)
            $display("tb_rtf_text_escaper: PASS");
        else
            $display("tb_rtf_text_escaper: FAIL");
        $finish;
    end

endmodule
